>>> hdl/rounded_rect_ordered_dither_macros.svh
// ----------------------------------------------------------------------------
// rounded rect ordered dither assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_ORDERED_DITHER_MACROS_SVH
`define ROUNDED_RECT_ORDERED_DITHER_MACROS_SVH

// implication checked at the same edge
`define RROD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrod check failed");

// implication checked at the following edge
`define RROD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrod check failed");

`endif

>>> hdl/rrod_pkg.sv
// ----------------------------------------------------------------------------
// rrod_pkg
// shared types, register codes and tables of the rounded rect dither block
// ----------------------------------------------------------------------------
package rrod_pkg;

    localparam int COORD_W    = 10;
    localparam int RADIUS_W   = 9;
    localparam int MODE_W     = 2;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYER_WIDTH   = 3'd0,
        REG_LAYER_HEIGHT  = 3'd1,
        REG_CORNER_RADIUS = 3'd2,
        REG_DITHER_MODE   = 3'd3,
        REG_FORE_COLOR    = 3'd4,
        REG_BACK_COLOR    = 3'd5
    } cfg_reg_e;

    typedef enum logic [MODE_W-1:0] {
        MODE_MIX = 2'd0,
        MODE_LR  = 2'd1,
        MODE_TB  = 2'd2
    } dither_mode_e;

    typedef struct packed {
        logic [COORD_W-1:0]  layer_width;
        logic [COORD_W-1:0]  layer_height;
        logic [RADIUS_W-1:0] corner_radius;
        logic [MODE_W-1:0]   dither_mode;
        logic [COLOR_W-1:0]  fore_color;
        logic [COLOR_W-1:0]  back_color;
    } cfg_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    localparam logic [23:0] CORNER_NIBBLES [9] = '{
        24'h000000, 24'h000001, 24'h000001, 24'h000012, 24'h000113,
        24'h000123, 24'h001234, 24'h011235, 24'h112346
    };

    // indexed by {column[2:0], row[2:0]}
    localparam logic [5:0] BAYER [64] = '{
        6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
        6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
        6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
        6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
        6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
        6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
        6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
        6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
    };

    // corner column limit for small radii, zero past the table rows
    function automatic logic [3:0] corner_lim(input logic [3:0] r,
                                              input logic [COORD_W-1:0] row);
        logic [31:0] nib;
        logic [3:0]  lim;
        nib = '0;
        lim = '0;
        if (r <= 4'd8)
        begin
            nib = {8'b0, CORNER_NIBBLES[r]};
        end
        if (row < COORD_W'(8))
        begin
            lim = nib[{row[2:0], 2'b00} +: 4];
        end
        return lim;
    endfunction

endpackage

>>> hdl/rounded_rect_ordered_dither.sv
// ----------------------------------------------------------------------------
// rounded_rect_ordered_dither
// rounded rectangle coverage with checkerboard or bayer gradient colouring
// ----------------------------------------------------------------------------
// accepted items pass stage registers s1 to s4 on the way to the output port
// throughput: one item per cycle if not stalled, from the four stage datapath
// stalled output lets empty stages behind it keep filling
// reset: valid bits cleared, width and height 1, other config registers 0
// ----------------------------------------------------------------------------
module rounded_rect_ordered_dither (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rrod_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rrod_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rrod_pkg::COORD_W-1:0]       pos_x,
    input  logic [rrod_pkg::COORD_W-1:0]       pos_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               draw_pixel,
    output logic [rrod_pkg::COLOR_W-1:0]       pixel_argb
);

    rrod_pkg::cfg_t      cfg_reg, cfg_next;
    rrod_pkg::stage_en_t en;
    logic [3:0]          v_reg, v_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rrod_pkg::REG_LAYER_WIDTH:   cfg_next.layer_width   = cfg_data;
                rrod_pkg::REG_LAYER_HEIGHT:  cfg_next.layer_height  = cfg_data;
                rrod_pkg::REG_CORNER_RADIUS: cfg_next.corner_radius = cfg_data[8:0];
                rrod_pkg::REG_DITHER_MODE:   cfg_next.dither_mode   = cfg_data[1:0];
                rrod_pkg::REG_FORE_COLOR:    cfg_next.fore_color    = cfg_data[7:0];
                rrod_pkg::REG_BACK_COLOR:    cfg_next.back_color    = cfg_data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // stage advances when empty or when the stage after it advances
    always_comb
    begin
        en.s4 = !v_reg[3] || out_ready;
        en.s3 = !v_reg[2] || en.s4;
        en.s2 = !v_reg[1] || en.s3;
        en.s1 = !v_reg[0] || en.s2;

        v_next[0] = en.s1 ? in_valid : v_reg[0];
        v_next[1] = en.s2 ? v_reg[0] : v_reg[1];
        v_next[2] = en.s3 ? v_reg[1] : v_reg[2];
        v_next[3] = en.s4 ? v_reg[2] : v_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg                 <= '0;
            cfg_reg.layer_width   <= 10'd1;
            cfg_reg.layer_height  <= 10'd1;
            cfg_reg.corner_radius <= '0;
            cfg_reg.dither_mode   <= '0;
            cfg_reg.fore_color    <= '0;
            cfg_reg.back_color    <= '0;
        end
        else
        begin
            v_reg   <= v_next;
            cfg_reg <= cfg_next;
        end
    end

    assign in_ready  = en.s1;
    assign out_valid = v_reg[3];

    rrod_datapath u_datapath (
        .clk         (clk),
        .cfg         (cfg_reg),
        .en          (en),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .draw_pixel  (draw_pixel),
        .pixel_argb  (pixel_argb)
    );

endmodule

>>> hdl/rrod_datapath.sv
// ----------------------------------------------------------------------------
// rrod_datapath
// four stage shape and dither datapath, each stage loads on its enable
// ----------------------------------------------------------------------------
module rrod_datapath (
    input  logic                            clk,
    input  rrod_pkg::cfg_t                  cfg,
    input  rrod_pkg::stage_en_t             en,
    input  logic [rrod_pkg::COORD_W-1:0]    pos_x,
    input  logic [rrod_pkg::COORD_W-1:0]    pos_y,
    output logic                            draw_pixel,
    output logic [rrod_pkg::COLOR_W-1:0]    pixel_argb
);

    typedef struct packed {
        logic [rrod_pkg::COORD_W-1:0]  x;
        logic [rrod_pkg::COORD_W-1:0]  y;
        logic                          inb;
        logic                          rzero;
        logic [rrod_pkg::RADIUS_W-1:0] rc;
        logic [6:0]                    bp;
        logic [rrod_pkg::COORD_W-1:0]  num;
        logic [rrod_pkg::COORD_W-1:0]  den;
        logic                          grad;
        logic                          par;
    } s1_t;

    typedef struct packed {
        logic [rrod_pkg::COORD_W-1:0]  xf;
        logic [rrod_pkg::COORD_W-1:0]  yf;
        logic                          inb;
        logic                          rzero;
        logic                          band;
        logic [rrod_pkg::RADIUS_W-1:0] rc;
        logic                          small_r;
        logic [17:0]                   rr;
        logic [16:0]                   prod;
        logic [rrod_pkg::COORD_W-1:0]  num;
        logic                          dz;
        logic                          grad;
        logic                          par;
    } s2_t;

    typedef struct packed {
        logic        inb;
        logic        rzero;
        logic        band;
        logic        small_r;
        logic        small_ok;
        logic [17:0] rr;
        logic [19:0] sqx;
        logic [19:0] sqy;
        logic        sel_fore;
    } s3_t;

    typedef struct packed {
        logic                         draw;
        logic [rrod_pkg::COLOR_W-1:0] color;
    } s4_t;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;

    logic [rrod_pkg::RADIUS_W-1:0] half_w;
    logic [rrod_pkg::RADIUS_W-1:0] half_h;
    logic [rrod_pkg::RADIUS_W-1:0] r_w;
    logic                          use_x;
    logic [rrod_pkg::COORD_W-1:0]  lim_x;
    logic [rrod_pkg::COORD_W-1:0]  lim_y;
    logic signed [10:0]            dx;
    logic signed [10:0]            dy;
    logic signed [21:0]            sqx_full;
    logic signed [21:0]            sqy_full;
    logic [20:0]                   dist_sq;
    logic                          circle_ok;
    logic                          covered;
    logic [rrod_pkg::COLOR_W-1:0]  color;

    // stage 1: bounds, radius clamp, bayer and divisor selection
    always_comb
    begin
        half_w = cfg.layer_width[rrod_pkg::COORD_W-1:1];
        half_h = cfg.layer_height[rrod_pkg::COORD_W-1:1];
        r_w    = (cfg.corner_radius > half_w) ? half_w : cfg.corner_radius;
        use_x  = (cfg.dither_mode == rrod_pkg::MODE_LR);

        s1_next.x     = pos_x;
        s1_next.y     = pos_y;
        s1_next.inb   = (pos_x < cfg.layer_width) && (pos_y < cfg.layer_height);
        s1_next.rzero = (cfg.corner_radius == '0);
        s1_next.rc    = (r_w > half_h) ? half_h : r_w;
        s1_next.bp    = {1'b0, rrod_pkg::BAYER[{pos_x[2:0], pos_y[2:0]}]} + 7'd1;
        s1_next.num   = use_x ? pos_x : pos_y;
        s1_next.den   = use_x ? (cfg.layer_width - 10'd1) : (cfg.layer_height - 10'd1);
        s1_next.grad  = (cfg.dither_mode != rrod_pkg::MODE_MIX);
        s1_next.par   = pos_x[0] ^ pos_y[0];
    end

    // stage 2: straight band test, corner fold, products
    always_comb
    begin
        lim_x = cfg.layer_width - {1'b0, s1_reg.rc} - 10'd1;
        lim_y = cfg.layer_height - {1'b0, s1_reg.rc} - 10'd1;

        s2_next.band  = (s1_reg.x > {1'b0, s1_reg.rc} && s1_reg.x < lim_x)
                     || (s1_reg.y > {1'b0, s1_reg.rc} && s1_reg.y < lim_y);
        s2_next.xf    = (s1_reg.x >= {1'b0, cfg.layer_width[rrod_pkg::COORD_W-1:1]})
                      ? (cfg.layer_width - 10'd1 - s1_reg.x) : s1_reg.x;
        s2_next.yf    = (s1_reg.y >= {1'b0, cfg.layer_height[rrod_pkg::COORD_W-1:1]})
                      ? (cfg.layer_height - 10'd1 - s1_reg.y) : s1_reg.y;
        s2_next.inb     = s1_reg.inb;
        s2_next.rzero   = s1_reg.rzero;
        s2_next.rc      = s1_reg.rc;
        s2_next.small_r = (s1_reg.rc <= 9'd8);
        s2_next.rr      = {9'b0, s1_reg.rc} * {8'b0, ({1'b0, s1_reg.rc} + 10'd1)};
        s2_next.prod    = {10'b0, s1_reg.bp} * {7'b0, s1_reg.den};
        s2_next.num     = s1_reg.num;
        s2_next.dz      = (s1_reg.den == '0);
        s2_next.grad    = s1_reg.grad;
        s2_next.par     = s1_reg.par;
    end

    // stage 3: corner distances squared, small radius table, threshold compare
    always_comb
    begin
        dx       = $signed({2'b0, s2_reg.rc}) - $signed({1'b0, s2_reg.xf});
        dy       = $signed({2'b0, s2_reg.rc}) - $signed({1'b0, s2_reg.yf});
        sqx_full = dx * dx;
        sqy_full = dy * dy;

        s3_next.inb      = s2_reg.inb;
        s3_next.rzero    = s2_reg.rzero;
        s3_next.band     = s2_reg.band;
        s3_next.small_r  = s2_reg.small_r;
        s3_next.small_ok = ({6'b0, rrod_pkg::corner_lim(s2_reg.rc[3:0], s2_reg.yf)}
                            <= s2_reg.xf);
        s3_next.rr       = s2_reg.rr;
        s3_next.sqx      = sqx_full[19:0];
        s3_next.sqy      = sqy_full[19:0];
        s3_next.sel_fore = s2_reg.grad
                         ? (!s2_reg.dz && ({1'b0, s2_reg.num, 6'b0} >= s2_reg.prod))
                         : s2_reg.par;
    end

    // stage 4: inside decision and colour choice
    always_comb
    begin
        dist_sq   = {1'b0, s3_reg.sqx} + {1'b0, s3_reg.sqy};
        circle_ok = ({3'b0, s3_reg.rr} >= dist_sq);
        covered   = s3_reg.inb
                 && (s3_reg.rzero || s3_reg.band
                     || (s3_reg.small_r ? s3_reg.small_ok : circle_ok));
        color     = s3_reg.sel_fore ? cfg.fore_color : cfg.back_color;

        s4_next.draw  = covered && (color != '0);
        s4_next.color = (covered && (color != '0)) ? color : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_reg <= s1_next;
        end
        if (en.s2)
        begin
            s2_reg <= s2_next;
        end
        if (en.s3)
        begin
            s3_reg <= s3_next;
        end
        if (en.s4)
        begin
            s4_reg <= s4_next;
        end
    end

    assign draw_pixel = s4_reg.draw;
    assign pixel_argb = s4_reg.color;

endmodule

>>> hdl/rrod_checker.sv
// ----------------------------------------------------------------------------
// rrod_checker
// port level checks of the rounded rect dither block, bound to the top level
// ----------------------------------------------------------------------------
`include "rounded_rect_ordered_dither_macros.svh"

module rrod_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic                               draw_pixel,
    input  logic [rrod_pkg::COLOR_W-1:0]       pixel_argb
);

    // stalled result holds
    `RROD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(draw_pixel) && $stable(pixel_argb))

    // no draw means clear colour
    `RROD_ASSERT_SAME(a_nodraw_clear, out_valid && !draw_pixel, pixel_argb == '0)

    // a drawn pixel never carries the clear colour
    `RROD_ASSERT_SAME(a_draw_colour, out_valid && draw_pixel, pixel_argb != '0)

    // an accepted item reaches the output through stages s1 to s4 when not stalled
    `RROD_ASSERT_NEXT(a_latency,
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready,
        out_valid)

endmodule

bind rounded_rect_ordered_dither rrod_checker u_rrod_checker (.*);

>>> verif/tb_rounded_rect_ordered_dither.sv
// ----------------------------------------------------------------------------
// tb_rounded_rect_ordered_dither
// self-checking bench for the rounded rectangle dither block: a behavioural
// pixel predictor fills a queue of expected pixels at input acceptance and
// every output item is compared field by field against the oldest entry.
// directed corner cases are followed by random layers, positions and
// colours under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_rounded_rect_ordered_dither;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int GRADIENT_SCALE = 64;

    localparam logic [rrod_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [rrod_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [rrod_pkg::MODE_W-1:0]    MODE_SPARE   = 2'd3;

    localparam int CORNER_LIM_TAB [9] = '{
        'h0, 'h01, 'h01, 'h12, 'h113, 'h123, 'h1234, 'h11235, 'h112346
    };

    // first index is the column
    localparam int BAYER_TB [8][8] = '{
        '{0, 32, 8, 40, 2, 34, 10, 42},
        '{48, 16, 56, 24, 50, 18, 58, 26},
        '{12, 44, 4, 36, 14, 46, 6, 38},
        '{60, 28, 52, 20, 62, 30, 54, 22},
        '{3, 35, 11, 43, 1, 33, 9, 41},
        '{51, 19, 59, 27, 49, 17, 57, 25},
        '{15, 47, 7, 39, 13, 45, 5, 37},
        '{63, 31, 55, 23, 61, 29, 53, 21}
    };

    typedef struct packed {
        logic                         draw;
        logic [rrod_pkg::COLOR_W-1:0] color;
    } pixel_res_t;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            cfg_valid   = 1'b0;
    logic                            cfg_ready;
    logic [rrod_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [rrod_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                            in_valid    = 1'b0;
    logic                            in_ready;
    logic [rrod_pkg::COORD_W-1:0]    pos_x       = '0;
    logic [rrod_pkg::COORD_W-1:0]    pos_y       = '0;
    logic                            out_valid;
    logic                            out_ready   = 1'b0;
    logic                            draw_pixel;
    logic [rrod_pkg::COLOR_W-1:0]    pixel_argb;

    // predictor copy of the register file
    logic [rrod_pkg::COORD_W-1:0]  layer_w;
    logic [rrod_pkg::COORD_W-1:0]  layer_h;
    logic [rrod_pkg::RADIUS_W-1:0] radius;
    logic [rrod_pkg::MODE_W-1:0]   mode;
    logic [rrod_pkg::COLOR_W-1:0]  fg;
    logic [rrod_pkg::COLOR_W-1:0]  bg;

    pixel_res_t expected_pixels [$];
    int         fail_count    = 0;
    int         cycle_count   = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    rounded_rect_ordered_dither DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .draw_pixel  (draw_pixel),
        .pixel_argb  (pixel_argb)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit covers_pixel(int w, int h, int r, int x, int y);
        int dx;
        int dy;
        int lim;
        if (r == 0)
            return 1'b1;
        if (r > w / 2)
            r = w / 2;
        if (r > h / 2)
            r = h / 2;
        if ((x > r && x < w - r - 1) || (y > r && y < h - r - 1))
            return 1'b1;
        // fold into the top left corner
        if (y >= h / 2)
            y = h - 1 - y;
        if (x >= w / 2)
            x = w - 1 - x;
        if (r <= 8)
        begin
            lim = 0;
            if (y < 8)
                lim = (CORNER_LIM_TAB[r] >> (4 * y)) & 'hF;
            return x >= lim;
        end
        dx = r - x;
        dy = r - y;
        return r * (r + 1) >= dx * dx + dy * dy;
    endfunction

    function automatic pixel_res_t predict_pixel(logic [rrod_pkg::COORD_W-1:0] x,
                                                 logic [rrod_pkg::COORD_W-1:0] y);
        pixel_res_t                   res;
        int                           thr;
        logic [rrod_pkg::COLOR_W-1:0] col;
        res = '0;
        thr = 0;
        if (x >= layer_w || y >= layer_h)
            return res;
        if (!covers_pixel(int'(layer_w), int'(layer_h), int'(radius), int'(x), int'(y)))
            return res;
        if (mode == rrod_pkg::MODE_MIX)
        begin
            col = (x[0] ^ y[0]) ? fg : bg;
        end
        else
        begin
            if (mode == rrod_pkg::MODE_LR)
            begin
                if (layer_w > 1)
                    thr = (int'(x) * GRADIENT_SCALE) / (int'(layer_w) - 1);
            end
            else if (layer_h > 1)
            begin
                thr = (int'(y) * GRADIENT_SCALE) / (int'(layer_h) - 1);
            end
            col = (thr > BAYER_TB[x[2:0]][y[2:0]]) ? fg : bg;
        end
        if (col != '0)
        begin
            res.draw  = 1'b1;
            res.color = col;
        end
        return res;
    endfunction

    function automatic logic [rrod_pkg::CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(5))
            0: return rrod_pkg::CFG_DATA_W'($urandom_range(3));
            1: return rrod_pkg::CFG_DATA_W'($urandom_range(24, 1));
            2: return rrod_pkg::CFG_DATA_W'($urandom_range(200, 16));
            3: return rrod_pkg::CFG_DATA_W'(1023);
            default: return rrod_pkg::CFG_DATA_W'($urandom_range(1023, 1));
        endcase
    endfunction

    function automatic logic [rrod_pkg::CFG_DATA_W-1:0] pick_color();
        logic [rrod_pkg::COLOR_W-1:0] col;
        col = ($urandom_range(5) == 0) ? '0 : rrod_pkg::COLOR_W'($urandom_range(255));
        return {2'($urandom_range(3)), col};
    endfunction

    // positions cluster around the corners, some fall outside the layer
    function automatic logic [rrod_pkg::COORD_W-1:0] pick_coord(int size, int rad);
        int span;
        span = rad + 3;
        if (span > size - 1)
            span = size - 1;
        if (span < 0)
            span = 0;
        if (size == 0)
            return rrod_pkg::COORD_W'($urandom_range(1023));
        case ($urandom_range(9))
            0:       return rrod_pkg::COORD_W'($urandom_range(1023));
            1, 2:    return rrod_pkg::COORD_W'($urandom_range(span));
            3, 4:    return rrod_pkg::COORD_W'(size - 1 - int'($urandom_range(span)));
            default: return rrod_pkg::COORD_W'($urandom_range(size - 1));
        endcase
    endfunction

    task automatic reset_predictor();
        layer_w = 1;
        layer_h = 1;
        radius  = '0;
        mode    = rrod_pkg::MODE_MIX;
        fg      = '0;
        bg      = '0;
    endtask

    task automatic send_pixel(logic [rrod_pkg::COORD_W-1:0] x,
                              logic [rrod_pkg::COORD_W-1:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= x;
        pos_y    <= y;
        do
            @(posedge clk);
        while (!in_ready);
        expected_pixels.push_back(predict_pixel(x, y));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [rrod_pkg::CFG_IDX_W-1:0] idx,
                             logic [rrod_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rrod_pkg::REG_LAYER_WIDTH:   layer_w = data[rrod_pkg::COORD_W-1:0];
            rrod_pkg::REG_LAYER_HEIGHT:  layer_h = data[rrod_pkg::COORD_W-1:0];
            rrod_pkg::REG_CORNER_RADIUS: radius  = data[rrod_pkg::RADIUS_W-1:0];
            rrod_pkg::REG_DITHER_MODE:   mode    = data[rrod_pkg::MODE_W-1:0];
            rrod_pkg::REG_FORE_COLOR:    fg      = data[rrod_pkg::COLOR_W-1:0];
            rrod_pkg::REG_BACK_COLOR:    bg      = data[rrod_pkg::COLOR_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_layer(logic [rrod_pkg::CFG_DATA_W-1:0] w,
                             logic [rrod_pkg::CFG_DATA_W-1:0] h,
                             logic [rrod_pkg::CFG_DATA_W-1:0] r,
                             logic [rrod_pkg::CFG_DATA_W-1:0] m,
                             logic [rrod_pkg::CFG_DATA_W-1:0] f,
                             logic [rrod_pkg::CFG_DATA_W-1:0] b);
        wait_drain();
        write_reg(rrod_pkg::REG_LAYER_WIDTH, w);
        write_reg(rrod_pkg::REG_LAYER_HEIGHT, h);
        write_reg(rrod_pkg::REG_CORNER_RADIUS, r);
        write_reg(rrod_pkg::REG_DITHER_MODE, m);
        write_reg(rrod_pkg::REG_FORE_COLOR, f);
        write_reg(rrod_pkg::REG_BACK_COLOR, b);
    endtask

    task automatic test_reset_state();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
    endtask

    task automatic test_mix_extremes();
        set_layer(10'd1023, 10'd1023, 10'd0, rrod_pkg::MODE_MIX, 10'h0FF, 10'h001);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1, 10'd0);
        send_pixel(10'd1022, 10'd1022);
        send_pixel(10'd1023, 10'd5);
        send_pixel(10'd5, 10'd1023);
    endtask

    task automatic test_gradient_divisor();
        // single column and single row give a zero divisor
        set_layer(10'd1, 10'd1023, 10'd0, rrod_pkg::MODE_LR, 10'h0AA, 10'h055);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd0, 10'd1022);
        set_layer(10'd1023, 10'd1, 10'd0, rrod_pkg::MODE_TB, 10'h0AA, 10'h055);
        send_pixel(10'd1022, 10'd0);
        set_layer(10'd1023, 10'd1023, 10'd0, MODE_SPARE, 10'h0AA, 10'h055);
        send_pixel(10'd3, 10'd1022);
        send_pixel(10'd3, 10'd0);
    endtask

    task automatic test_corner_table();
        set_layer(10'd40, 10'd40, 10'd8, rrod_pkg::MODE_MIX, 10'h012, 10'h034);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd0, 10'd8);
        send_pixel(10'd6, 10'd0);
        send_pixel(10'd5, 10'd0);
        send_pixel(10'd39, 10'd39);
    endtask

    task automatic test_circle_corner();
        // radius is clamped to half the height
        set_layer(10'd100, 10'd60, 10'd200, rrod_pkg::MODE_TB, 10'h3C1, 10'h2E7);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd30, 10'd0);
        send_pixel(10'd99, 10'd59);
        send_pixel(10'd50, 10'd30);
    endtask

    task automatic test_clear_and_empty();
        set_layer(10'd0, 10'd8, 10'd0, rrod_pkg::MODE_MIX, 10'h0FF, 10'h0FF);
        send_pixel(10'd0, 10'd0);
        set_layer(10'd8, 10'd8, 10'd0, rrod_pkg::MODE_MIX, 10'h300, 10'h000);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1, 10'd0);
        // unused register indexes leave the layer unchanged
        wait_drain();
        write_reg(REG_SPARE_LO, 10'h3FF);
        write_reg(REG_SPARE_HI, 10'h155);
        send_pixel(10'd0, 10'd1);
    endtask

    task automatic test_random_phase(int send_pct, int recv_pct, int n_items);
        int                              sent;
        int                              seg_len;
        int                              k;
        logic [rrod_pkg::CFG_DATA_W-1:0] r_data;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent          = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(5))
                0:       r_data = '0;
                1, 2:    r_data = rrod_pkg::CFG_DATA_W'($urandom_range(8, 1));
                3:       r_data = rrod_pkg::CFG_DATA_W'($urandom_range(64, 9));
                4:       r_data = rrod_pkg::CFG_DATA_W'($urandom_range(511));
                default: r_data = rrod_pkg::CFG_DATA_W'($urandom_range(1023));
            endcase
            set_layer(pick_size(), pick_size(), r_data,
                      rrod_pkg::CFG_DATA_W'($urandom_range(1023)),
                      pick_color(), pick_color());
            seg_len = $urandom_range(80, 20);
            for (k = 0; k < seg_len; k++)
            begin
                // hold the sender until the pipeline has emptied
                if (k == seg_len / 2 && $urandom_range(3) == 0)
                    wait_drain();
                send_pixel(pick_coord(int'(layer_w), int'(radius)),
                           pick_coord(int'(layer_h), int'(radius)));
            end
            sent += seg_len;
        end
        wait_drain();
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        pixel_res_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected item: draw_pixel %0d pixel_argb 0x%02h",
                       draw_pixel, pixel_argb);
                fail_count++;
            end
            else
            begin
                exp_res = expected_pixels.pop_front();
                if (draw_pixel !== exp_res.draw)
                begin
                    $error("draw_pixel mismatch: expected %0d, actual %0d",
                           exp_res.draw, draw_pixel);
                    fail_count++;
                end
                if (pixel_argb !== exp_res.color)
                begin
                    $error("pixel_argb mismatch: expected 0x%02h, actual 0x%02h",
                           exp_res.color, pixel_argb);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        reset_predictor();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_mix_extremes();
        test_gradient_divisor();
        test_corner_table();
        test_circle_corner();
        test_clear_and_empty();
        test_random_phase(0, 0, 450);
        test_random_phase(54, 0, 450);
        test_random_phase(0, 54, 450);
        test_random_phase(34, 34, 450);
        wait_drain();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
